/* rtl/fpst_pkg.sv */
`default_nettype none

package fpst_pkg;

    // Table geometry
    localparam int SIZE    = 1024;
    localparam int ADDR_W  = $clog2(SIZE);
    localparam int INDEX_W = 11;
    localparam int DATA_W  = 32;
    // Node position plus one bit of headroom for the upward step
    localparam int POS_W   = INDEX_W + 1;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_PUSH
    } state_t;

endpackage

`default_nettype wire

/* rtl/fpst_req_if.sv */
`default_nettype none

interface fpst_req_if import fpst_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

`default_nettype wire

/* rtl/fpst_rsp_if.sv */
`default_nettype none

interface fpst_rsp_if import fpst_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  prefix_sum;

    modport source (output valid, output prefix_sum, input ready);
    modport sink   (input valid, input prefix_sum, output ready);
endinterface

`default_nettype wire

/* rtl/fpst_ram.sv */
`default_nettype none

module fpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/fenwick_prefix_sum_table_top.sv */
// Binary indexed tree over 1024 positions, numbered 1 to 1024.
// Request channel (req): mode, index, value. Mode add puts value at index and
// returns nothing; mode query returns the wrapped 32-bit sum of positions 1
// through index on the response channel (rsp). Index 0 adds nothing and
// queries as 0; a query index above 1024 is taken as 1024.
// One request is worked at a time; req.ready is high only while idle.
// Each tree node visited is read, then accumulated or written back, on the one
// node memory and the one shared 32-bit adder. An add returns to idle after
// writing back its last node; a query goes on to a push step that loads its
// sum into the output register, raising rsp.valid, and then returns to idle.
// An add touches at most 11 nodes and a query at most 10.
// The response sits in an output register: the block takes new requests
// while a response waits, and a later query holds in its push step until
// rsp.ready frees the register.
// After reset the block clears the node memory, one word a cycle, with
// req.ready low; it then accepts requests.
`default_nettype none

module fenwick_prefix_sum_table_top import fpst_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fpst_req_if.sink    req,
    fpst_rsp_if.source  rsp
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                mode_reg, mode_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   node_addr;
    logic [DATA_W-1:0]   ram_rdata;

    logic [DATA_W-1:0]   alu_b;
    logic [DATA_W-1:0]   alu_out;
    logic [POS_W-1:0]    low_bit;
    logic [POS_W-1:0]    pos_up;
    logic [POS_W-1:0]    pos_down;
    logic [POS_W-1:0]    req_pos;
    logic                out_free;

    fpst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SIZE)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (node_addr),
        .rdata (ram_rdata)
    );

    // Node n lives at word n-1
    assign node_addr = ADDR_W'(pos_reg - POS_W'(1));

    // Shared adder: node plus value on an add, running sum plus node on a query
    assign alu_b   = (mode_reg == MODE_ADD) ? value_reg : sum_reg;
    assign alu_out = ram_rdata + alu_b;

    assign low_bit  = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_up   = pos_reg + low_bit;
    assign pos_down = pos_reg & (pos_reg - POS_W'(1));
    assign req_pos  = POS_W'(req.index);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.prefix_sum = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        mode_reg     <= mode_next;
        value_reg    <= value_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_addr;
        ram_wdata      = alu_out;

        // Drop the response once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    value_next = req.value;
                    sum_next   = '0;
                    if (req.mode == MODE_ADD)
                    begin
                        pos_next = req_pos;
                        if (req_pos != '0 && req_pos <= POS_W'(SIZE))
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        pos_next = (req_pos > POS_W'(SIZE)) ? POS_W'(SIZE) : req_pos;
                        state_next = (req_pos == '0) ? ST_PUSH : ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                if (mode_reg == MODE_ADD)
                begin
                    ram_we   = 1'b1;
                    pos_next = pos_up;
                    state_next = (pos_up > POS_W'(SIZE)) ? ST_IDLE : ST_READ;
                end
                else
                begin
                    sum_next = alu_out;
                    pos_next = pos_down;
                    state_next = (pos_down == '0) ? ST_PUSH : ST_READ;
                end
            end

            ST_PUSH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fpst_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 30;
    localparam int SCRIPT_LEN   = 25;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  value;
        logic               typed;
        logic [DATA_W-1:0]  want;
    } script_row_t;

    logic clk;
    logic rst_n;

    fpst_req_if req_ch ();
    fpst_rsp_if rsp_ch ();

    fenwick_prefix_sum_table_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the tree, node n held at node_sum[n]
    logic [DATA_W-1:0] node_sum [1:SIZE];
    logic [DATA_W-1:0] sums_due [$];
    bit                calm;
    int                error_count;

    // Directed part: typed results only where they follow at a glance
    script_row_t script [SCRIPT_LEN] = '{
        '{MODE_QUERY, 11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{MODE_QUERY, 11'd1024, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{MODE_QUERY, 11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{MODE_ADD,   11'd0,    32'h0000_0005, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd1025, 32'h0000_0007, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd2047, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd2047, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{MODE_ADD,   11'd1,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd1024, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1024, 32'h0000_0000, 1'b1, 32'h8000_0000},
        '{MODE_QUERY, 11'd0,    32'h1234_5678, 1'b1, 32'h0000_0000},
        '{MODE_ADD,   11'd1,    32'h8000_0000, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd512,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd511,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd512,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd513,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd1023, 32'h0000_0064, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1025, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd1024, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd2047, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{MODE_ADD,   11'd683,  32'h5555_5555, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1365, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
        '{MODE_QUERY, 11'd1,    32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    always #1 clk = ~clk;

    function automatic void tree_credit(input logic [POS_W-1:0] pos,
                                        input logic [DATA_W-1:0] amount);
        logic [POS_W-1:0] p;
        p = pos;
        // climb by the lowest set bit
        while (p >= 1 && p <= SIZE)
        begin
            node_sum[p] = node_sum[p] + amount;
            p = p + (p & (~p + 1'b1));
        end
    endfunction

    function automatic logic [DATA_W-1:0] prefix_total(input logic [INDEX_W-1:0] index);
        logic [POS_W-1:0]  p;
        logic [DATA_W-1:0] sum;
        p   = (index > SIZE) ? POS_W'(SIZE) : POS_W'(index);
        sum = '0;
        while (p != 0)
        begin
            sum = sum + node_sum[p];
            p   = p & (p - 1'b1);
        end
        return sum;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 9)
            return INDEX_W'($urandom_range(SIZE + 1, 2047));
        if (r < 13)
            return INDEX_W'(SIZE);
        if (r < 17)
            return INDEX_W'(1);
        if (r < 40)
            return INDEX_W'($urandom_range(1, 32));
        return INDEX_W'($urandom_range(1, SIZE));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'h7FFF_FFFF;
        if (r < 10)
            return 32'h8000_0000;
        if (r < 35)
            return DATA_W'($urandom_range(0, 200)) - 32'd100;
        return $urandom;
    endfunction

    task automatic send_request(input logic mode, input logic [INDEX_W-1:0] index,
                                input logic [DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode  = mode;
        req_ch.index = index;
        req_ch.value = value;
        // hold until the request is taken
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Queries in the directed table that carry a typed result
    logic [DATA_W-1:0] typed_want;
    bit                typed_pending;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (sums_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected response: prefix_sum=%h", rsp_ch.prefix_sum);
                end
                else if (rsp_ch.prefix_sum !== sums_due[0])
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("prefix_sum mismatch: expected %h, got %h",
                                 sums_due[0], rsp_ch.prefix_sum);
                    void'(sums_due.pop_front());
                end
                else
                    void'(sums_due.pop_front());
            end
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.mode == MODE_QUERY)
                    sums_due = {sums_due,
                                (typed_pending ? typed_want : prefix_total(req_ch.index))};
                else if (req_ch.index != 0 && req_ch.index <= SIZE)
                    tree_credit(POS_W'(req_ch.index), req_ch.value);
            end
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = MODE_ADD;
        req_ch.index  = '0;
        req_ch.value  = '0;
        calm          = 1'b0;
        error_count   = 0;
        typed_pending = 1'b0;
        typed_want    = '0;
        for (int n = 1; n <= SIZE; n++)
            node_sum[n] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            typed_pending = script[i].typed;
            typed_want    = script[i].want;
            send_request(script[i].mode, script[i].index, script[i].value);
        end
        typed_pending = 1'b0;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // switch between idle-free stretches and gappy ones
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            send_request(($urandom_range(0, 99) < 55) ? MODE_ADD : MODE_QUERY,
                         pick_index(), pick_value());
        end
        req_ch.valid = 1'b0;

        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
